>>> src/mad_pkg.sv
// shared types, constants and lookup functions of the mpeg audio header decoder
package mad_pkg;

    localparam logic [10:0] SYNC_WORD = 11'h7ff;

    localparam logic [1:0] VER_MPEG25 = 2'b00;
    localparam logic [1:0] VER_RSV    = 2'b01;
    localparam logic [1:0] VER_MPEG2  = 2'b10;
    localparam logic [1:0] VER_MPEG1  = 2'b11;

    localparam logic [1:0] LAYER_RSV  = 2'b00;
    localparam logic [1:0] MODE_MONO  = 2'b11;
    localparam logic [1:0] SR_IDX_RSV = 2'b11;
    localparam logic [3:0] BR_IDX_FREE = 4'd0;
    localparam logic [3:0] BR_IDX_BAD  = 4'd15;

    localparam int FDIV_SHIFT = 24;
    localparam int TDIV_SHIFT = 20;

    localparam logic [8:0] KBPS_G0L1 [0:14] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
        9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448};
    localparam logic [8:0] KBPS_G0L2 [0:14] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384};
    localparam logic [8:0] KBPS_G0L3 [0:14] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320};
    localparam logic [8:0] KBPS_G1L1 [0:14] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256};
    localparam logic [8:0] KBPS_G1L23 [0:14] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160};

    typedef struct packed {
        logic        ok;
        logic [1:0]  chan;
        logic [15:0] sr;
        logic [18:0] br;
        logic        l1;
        logic        pad;
        logic [17:0] num;
        logic [24:0] rcp;
        logic [7:0]  dv;
        logic [5:0]  d8;
        logic [20:0] rc2;
    } t_s1;

    typedef struct packed {
        logic        ok;
        logic [1:0]  chan;
        logic [15:0] sr;
        logic [18:0] br;
        logic [11:0] fb;
        logic [5:0]  d8;
        logic [20:0] rc2;
    } t_s3;

    typedef struct packed {
        logic        header_ok;
        logic [1:0]  channel_count;
        logic [15:0] sample_rate_hz;
        logic [18:0] bit_rate_bps;
        logic [11:0] frame_bytes;
        logic [13:0] duration_ticks;
    } t_res;

    function automatic logic [8:0] kbps_lookup(input logic grp, input logic [1:0] lay,
                                              input logic [3:0] idx);
        logic [8:0] v;
        v = 9'd0;
        if (idx != BR_IDX_BAD) begin
            if (!grp) begin
                case (lay)
                    2'd0:    v = KBPS_G0L1[idx];
                    2'd1:    v = KBPS_G0L2[idx];
                    default: v = KBPS_G0L3[idx];
                endcase
            end else begin
                case (lay)
                    2'd0:    v = KBPS_G1L1[idx];
                    default: v = KBPS_G1L23[idx];
                endcase
            end
        end
        return v;
    endfunction

    // floor(2^20 / d) for every rate / 8 that occurs
    function automatic logic [20:0] recip20(input logic [5:0] d);
        logic [20:0] r;
        case (d)
            6'd1:    r = 21'd1048576;
            6'd2:    r = 21'd524288;
            6'd3:    r = 21'd349525;
            6'd4:    r = 21'd262144;
            6'd5:    r = 21'd209715;
            6'd6:    r = 21'd174762;
            6'd7:    r = 21'd149796;
            6'd8:    r = 21'd131072;
            6'd10:   r = 21'd104857;
            6'd12:   r = 21'd87381;
            6'd14:   r = 21'd74898;
            6'd16:   r = 21'd65536;
            6'd18:   r = 21'd58254;
            6'd20:   r = 21'd52428;
            6'd22:   r = 21'd47662;
            6'd24:   r = 21'd43690;
            6'd28:   r = 21'd37449;
            6'd32:   r = 21'd32768;
            6'd36:   r = 21'd29127;
            6'd40:   r = 21'd26214;
            6'd44:   r = 21'd23831;
            6'd48:   r = 21'd21845;
            6'd52:   r = 21'd20164;
            6'd56:   r = 21'd18724;
            default: r = 21'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/mad_if.sv
// request channels of the mpeg audio header decoder
interface mad_hdr_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    modport source (output valid, output header_word, input ready);
    modport sink (input valid, input header_word, output ready);
endinterface

interface mad_res_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic [1:0]  channel_count;
    logic [15:0] sample_rate_hz;
    logic [18:0] bit_rate_bps;
    logic [11:0] frame_bytes;
    logic [13:0] duration_ticks;
    modport source (output valid, output header_ok, output channel_count,
                    output sample_rate_hz, output bit_rate_bps, output frame_bytes,
                    output duration_ticks, input ready);
    modport sink (input valid, input header_ok, input channel_count,
                  input sample_rate_hz, input bit_rate_bps, input frame_bytes,
                  input duration_ticks, output ready);
endinterface

>>> src/mad_decode.sv
// field decode, validity check and divider operand lookup
module mad_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [31:0]   i_header_word,
    output logic          o_valid,
    input  logic          i_ready,
    output mad_pkg::t_s1  o_s1
);
    import mad_pkg::*;

    logic        r_vld;
    t_s1         r_s1;
    t_s1         n_s1;
    logic        w_en;
    logic [1:0]  w_ver;
    logic [1:0]  w_lb;
    logic [3:0]  w_bri;
    logic [1:0]  w_sri;
    logic [1:0]  w_lay;
    logic [1:0]  w_shift;
    logic        w_grp;
    logic        w_ok;
    logic [8:0]  w_kbps;
    logic [15:0] w_base;
    logic [7:0]  w_a;
    logic [18:0] w_num;

    assign w_en    = !r_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld;
    assign o_s1    = r_s1;

    assign w_ver = i_header_word[20:19];
    assign w_lb  = i_header_word[18:17];
    assign w_bri = i_header_word[15:12];
    assign w_sri = i_header_word[11:10];
    assign w_lay = 2'd3 - w_lb;

    always_comb begin
        case (w_ver)
            VER_MPEG1: begin w_grp = 1'b0; w_shift = 2'd0; end
            VER_MPEG2: begin w_grp = 1'b1; w_shift = 2'd1; end
            default:   begin w_grp = 1'b1; w_shift = 2'd2; end
        endcase
    end

    assign w_ok = (i_header_word[31:21] == SYNC_WORD) && (w_ver != VER_RSV)
                  && (w_lb != LAYER_RSV) && (w_bri != BR_IDX_BAD)
                  && (w_bri != BR_IDX_FREE) && (w_sri != SR_IDX_RSV);

    assign w_kbps = kbps_lookup(w_grp, w_lay, w_bri);

    always_comb begin
        n_s1 = '0;
        case (w_sri)
            2'd0:    w_base = 16'd44100;
            2'd1:    w_base = 16'd48000;
            default: w_base = 16'd32000;
        endcase
        // frame length = a * kbps * 2^shift / dv, per sample-rate family and layer
        case ({w_sri, w_lay == 2'd0})
            3'b001:  begin w_a = 8'd40;  n_s1.dv = 8'd147; n_s1.rcp = 25'd114130;   end
            3'b000:  begin w_a = 8'd160; n_s1.dv = 8'd49;  n_s1.rcp = 25'd342392;   end
            3'b011:  begin w_a = 8'd1;   n_s1.dv = 8'd4;   n_s1.rcp = 25'd4194304;  end
            3'b010:  begin w_a = 8'd3;   n_s1.dv = 8'd1;   n_s1.rcp = 25'd16777216; end
            3'b101:  begin w_a = 8'd3;   n_s1.dv = 8'd8;   n_s1.rcp = 25'd2097152;  end
            default: begin w_a = 8'd9;   n_s1.dv = 8'd2;   n_s1.rcp = 25'd8388608;  end
        endcase
        w_num = 19'({10'd0, w_a} * {10'd0, w_kbps}) << w_shift;
        n_s1.d8  = 6'd1;
        n_s1.rc2 = recip20(6'd1);
        if (w_ok) begin
            n_s1.ok   = 1'b1;
            n_s1.chan = (i_header_word[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
            n_s1.sr   = w_base >> w_shift;
            n_s1.br   = 19'({10'd0, w_kbps} * 19'd1000);
            n_s1.l1   = (w_lay == 2'd0);
            n_s1.pad  = i_header_word[9];
            n_s1.num  = w_num[17:0];
            n_s1.d8   = w_kbps[8:3];
            n_s1.rc2  = recip20(w_kbps[8:3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_s1 <= n_s1;
        end
    end

endmodule

>>> src/mad_fdiv.sv
// two-stage reciprocal divider for the frame length
module mad_fdiv (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mad_pkg::t_s1  i_s1,
    output logic          o_valid,
    input  logic          i_ready,
    output mad_pkg::t_s3  o_s3
);
    import mad_pkg::*;

    logic        r_vld2;
    logic        r_vld3;
    t_s1         r_s2;
    logic [42:0] r_prod;
    t_s3         r_s3;
    t_s3         n_s3;
    logic        w_en2;
    logic        w_en3;
    logic [17:0] w_q0;
    logic [25:0] w_rem;
    logic [17:0] w_q;
    logic [17:0] w_qp;

    assign w_en3   = !r_vld3 || i_ready;
    assign w_en2   = !r_vld2 || w_en3;
    assign o_ready = w_en2;
    assign o_valid = r_vld3;
    assign o_s3    = r_s3;

    assign w_q0  = r_prod[FDIV_SHIFT+17:FDIV_SHIFT];
    assign w_rem = {8'd0, r_s2.num} - 26'({8'd0, w_q0} * {18'd0, r_s2.dv});
    assign w_q   = w_q0 + ((w_rem >= {18'd0, r_s2.dv}) ? 18'd1 : 18'd0);
    assign w_qp  = w_q + {17'd0, r_s2.pad};

    always_comb begin
        n_s3.ok   = r_s2.ok;
        n_s3.chan = r_s2.chan;
        n_s3.sr   = r_s2.sr;
        n_s3.br   = r_s2.br;
        n_s3.d8   = r_s2.d8;
        n_s3.rc2  = r_s2.rc2;
        n_s3.fb   = r_s2.l1 ? {w_qp[9:0], 2'b00} : w_qp[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_en2) r_vld2 <= i_valid;
            if (w_en3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && i_valid) begin
            r_s2   <= i_s1;
            r_prod <= 43'({25'd0, i_s1.num} * {18'd0, i_s1.rcp});
        end
        if (w_en3 && r_vld2) begin
            r_s3 <= n_s3;
        end
    end

endmodule

>>> src/mad_tdiv.sv
// three-stage reciprocal divider for the frame duration, last stage is the output register
module mad_tdiv (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mad_pkg::t_s3  i_s3,
    output logic          o_valid,
    input  logic          i_ready,
    output mad_pkg::t_res o_res
);
    import mad_pkg::*;

    logic        r_vld4;
    logic        r_vld5;
    logic        r_vld6;
    t_s3         r_s4;
    logic [17:0] r_n2;
    t_s3         r_s5;
    logic [17:0] r_n5;
    logic [38:0] r_prod;
    t_res        r_res;
    t_res        n_res;
    logic        w_en4;
    logic        w_en5;
    logic        w_en6;
    logic [17:0] w_q0;
    logic [23:0] w_rem;
    logic [17:0] w_q;

    assign w_en6   = !r_vld6 || i_ready;
    assign w_en5   = !r_vld5 || w_en6;
    assign w_en4   = !r_vld4 || w_en5;
    assign o_ready = w_en4;
    assign o_valid = r_vld6;
    assign o_res   = r_res;

    assign w_q0  = r_prod[TDIV_SHIFT+17:TDIV_SHIFT];
    assign w_rem = {6'd0, r_n5} - 24'({6'd0, w_q0} * {18'd0, r_s5.d8});
    assign w_q   = w_q0 + ((w_rem >= {18'd0, r_s5.d8}) ? 18'd1 : 18'd0);

    always_comb begin
        n_res.header_ok      = r_s5.ok;
        n_res.channel_count  = r_s5.chan;
        n_res.sample_rate_hz = r_s5.sr;
        n_res.bit_rate_bps   = r_s5.br;
        n_res.frame_bytes    = r_s5.fb;
        n_res.duration_ticks = w_q[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else begin
            if (w_en4) r_vld4 <= i_valid;
            if (w_en5) r_vld5 <= r_vld4;
            if (w_en6) r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && i_valid) begin
            r_s4 <= i_s3;
            r_n2 <= 18'({6'd0, i_s3.fb} * 18'd90);
        end
        if (w_en5 && r_vld4) begin
            r_s5   <= r_s4;
            r_n5   <= r_n2;
            r_prod <= 39'({21'd0, r_n2} * {18'd0, r_s4.rc2});
        end
        if (w_en6 && r_vld5) begin
            r_res <= n_res;
        end
    end

endmodule

>>> src/mpeg_audio_header_decoder_core.sv
// top level of the mpeg audio frame header decoder
//
// i_hdr carries one 32-bit frame header per request, first byte in bits 31..24.
// o_res returns one result request per header, in order: header_ok, channel
// count, sample rate, bit rate, frame length in bytes and frame duration in
// 90 kHz ticks. an invalid header gives header_ok low and all other fields zero.
// from acceptance to o_res.valid a header passes six register stages:
// one decode stage, two of the frame length divider (reciprocal multiply, then
// remainder correction) and three of the duration divider (scale, reciprocal
// multiply, correction). throughput is one header per cycle unless o_res stalls;
// every stage has its own valid bit and takes a new request whenever it is empty
// or moving on. reset clears all valid bits; no request is in flight afterwards.
// when o_res.ready is low the result holds and the pipeline fills up behind
// it; i_hdr.ready drops once all six stages hold a request, nothing is lost.
module mpeg_audio_header_decoder_core (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mad_hdr_if.sink   i_hdr,
    mad_res_if.source o_res
);
    import mad_pkg::*;

    logic w_v1;
    logic w_r1;
    t_s1  w_s1;
    logic w_v3;
    logic w_r3;
    t_s3  w_s3;
    t_res w_res;

    mad_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_hdr.valid),
        .o_ready       (i_hdr.ready),
        .i_header_word (i_hdr.header_word),
        .o_valid       (w_v1),
        .i_ready       (w_r1),
        .o_s1          (w_s1)
    );

    mad_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_s1    (w_s1),
        .o_valid (w_v3),
        .i_ready (w_r3),
        .o_s3    (w_s3)
    );

    mad_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_r3),
        .i_s3    (w_s3),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (w_res)
    );

    assign o_res.header_ok      = w_res.header_ok;
    assign o_res.channel_count  = w_res.channel_count;
    assign o_res.sample_rate_hz = w_res.sample_rate_hz;
    assign o_res.bit_rate_bps   = w_res.bit_rate_bps;
    assign o_res.frame_bytes    = w_res.frame_bytes;
    assign o_res.duration_ticks = w_res.duration_ticks;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.header_ok |-> o_res.channel_count == 2'd0
        && o_res.sample_rate_hz == 16'd0 && o_res.bit_rate_bps == 19'd0
        && o_res.frame_bytes == 12'd0 && o_res.duration_ticks == 14'd0)
        else $error("invalid header with nonzero fields");
    a_good_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.header_ok |-> o_res.channel_count != 2'd0
        && o_res.frame_bytes != 12'd0 && o_res.bit_rate_bps != 19'd0)
        else $error("valid header with empty fields");
`endif

endmodule

>>> dv/mpeg_audio_header_decoder_core_tb.sv
// testbench of the mpeg audio frame header decoder: directed and random headers checked against a predictor
module mpeg_audio_header_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mad_pkg::*;

    logic i_clk;
    logic i_rst_n;
    mad_hdr_if hdr_if ();
    mad_res_if res_if ();

    mpeg_audio_header_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_if.sink),
        .o_res   (res_if.source)
    );

    t_res decoded_q[$];
    int   error_count;
    bit   stall_en;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned rate_kbps(input bit grp, input int unsigned lay,
                                              input logic [3:0] idx);
        int unsigned g0l1 [15] = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352,
                                   384, 416, 448};
        int unsigned g0l2 [15] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                   256, 320, 384};
        int unsigned g0l3 [15] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                   224, 256, 320};
        int unsigned g1l1 [15] = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176,
                                   192, 224, 256};
        int unsigned g1lx [15] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                   144, 160};
        if (!grp) begin
            if (lay == 1) return g0l1[idx];
            if (lay == 2) return g0l2[idx];
            return g0l3[idx];
        end
        if (lay == 1) return g1l1[idx];
        return g1lx[idx];
    endfunction

    function automatic t_res decode_header(input logic [31:0] h);
        t_res r;
        logic [1:0] ver;
        logic [1:0] lay_bits;
        logic [3:0] br_idx;
        logic [1:0] sr_idx;
        int unsigned base_hz [3] = '{44100, 48000, 32000};
        int unsigned lay;
        int unsigned shift;
        bit grp;
        longint unsigned sr;
        longint unsigned br;
        longint unsigned fb;
        r = '0;
        ver = h[20:19];
        lay_bits = h[18:17];
        br_idx = h[15:12];
        sr_idx = h[11:10];
        if (h[31:21] != SYNC_WORD) return r;
        if (ver == VER_RSV || lay_bits == LAYER_RSV || br_idx == BR_IDX_BAD ||
            sr_idx == SR_IDX_RSV) return r;
        grp = (ver != VER_MPEG1);
        shift = (ver == VER_MPEG1) ? 0 : (ver == VER_MPEG2) ? 1 : 2;
        lay = 4 - lay_bits;
        sr = base_hz[sr_idx] >> shift;
        br = rate_kbps(grp, lay, br_idx) * 1000;
        if (br == 0) return r;
        if (lay == 1) fb = (12 * br / sr + h[9]) * 4;
        else fb = 144 * br / sr + h[9];
        r.header_ok = 1'b1;
        r.channel_count = (h[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
        r.sample_rate_hz = sr[15:0];
        r.bit_rate_bps = br[18:0];
        r.frame_bytes = fb[11:0];
        r.duration_ticks = 14'((fb * 720000) / br);
        return r;
    endfunction

    // receiver: stalls in random runs
    initial begin
        int stall_run;
        res_if.ready <= 1'b0;
        stall_run = 0;
        forever begin
            @(posedge i_clk);
            if (stall_run > 0) begin
                stall_run--;
                res_if.ready <= 1'b0;
            end else if (stall_en && $urandom_range(0, 7) == 0) begin
                stall_run = $urandom_range(0, 12);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.header_ok, res_if.channel_count, res_if.sample_rate_hz,
                    res_if.bit_rate_bps, res_if.frame_bytes, res_if.duration_ticks};
            if (decoded_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                error_count++;
            end else begin
                exp_r = decoded_q.pop_front();
                if (got.header_ok != exp_r.header_ok) begin
                    $display("%0t header_ok exp %0d got %0d", $time, exp_r.header_ok,
                             got.header_ok);
                    error_count++;
                end
                if (got.channel_count != exp_r.channel_count) begin
                    $display("%0t channel_count exp %0d got %0d", $time,
                             exp_r.channel_count, got.channel_count);
                    error_count++;
                end
                if (got.sample_rate_hz != exp_r.sample_rate_hz) begin
                    $display("%0t sample_rate_hz exp %0d got %0d", $time,
                             exp_r.sample_rate_hz, got.sample_rate_hz);
                    error_count++;
                end
                if (got.bit_rate_bps != exp_r.bit_rate_bps) begin
                    $display("%0t bit_rate_bps exp %0d got %0d", $time,
                             exp_r.bit_rate_bps, got.bit_rate_bps);
                    error_count++;
                end
                if (got.frame_bytes != exp_r.frame_bytes) begin
                    $display("%0t frame_bytes exp %0d got %0d", $time,
                             exp_r.frame_bytes, got.frame_bytes);
                    error_count++;
                end
                if (got.duration_ticks != exp_r.duration_ticks) begin
                    $display("%0t duration_ticks exp %0d got %0d", $time,
                             exp_r.duration_ticks, got.duration_ticks);
                    error_count++;
                end
            end
        end
    end

    int burst_left;

    // one request; valid stays high across a burst
    task automatic send_header(input logic [31:0] h);
        if (burst_left == 0) begin
            hdr_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) == 0) burst_left = 60;
        end
        hdr_if.valid <= 1'b1;
        hdr_if.header_word <= h;
        @(posedge i_clk);
        while (!hdr_if.ready) @(posedge i_clk);
        decoded_q.push_back(decode_header(h));
        burst_left--;
    endtask

    function automatic logic [31:0] good_header();
        logic [31:0] h;
        h = $urandom;
        h[31:21] = SYNC_WORD;
        if (h[20:19] == VER_RSV) h[20:19] = VER_MPEG1;
        if (h[18:17] == LAYER_RSV) h[18:17] = 2'b01;
        h[15:12] = 4'($urandom_range(1, 14));
        h[11:10] = 2'($urandom_range(0, 2));
        return h;
    endfunction

    task automatic test_extremes();
        send_header(32'h0000_0000);
        send_header(32'hffff_ffff);
        send_header(32'hffdf_ffff);
        send_header(32'hfffb_e000);
        send_header(32'hfffb_e2c0);
        send_header(32'hffe3_e200);
        send_header(32'hfff7_1840);
    endtask

    task automatic test_invalid_fields();
        logic [31:0] h;
        h = good_header(); h[20:19] = VER_RSV; send_header(h);
        h = good_header(); h[18:17] = LAYER_RSV; send_header(h);
        h = good_header(); h[15:12] = BR_IDX_FREE; send_header(h);
        h = good_header(); h[15:12] = BR_IDX_BAD; send_header(h);
        h = good_header(); h[11:10] = SR_IDX_RSV; send_header(h);
        h = good_header(); h[26] = 1'b0; send_header(h);
    endtask

    task automatic test_versions_layers();
        logic [31:0] h;
        for (int v = 0; v < 4; v++) begin
            for (int l = 1; l < 4; l++) begin
                h = good_header();
                h[20:19] = 2'(v); h[18:17] = 2'(l);
                if (v != 1) send_header(h);
            end
        end
    endtask

    task automatic test_random();
        logic [31:0] h;
        repeat (1830) begin
            if ($urandom_range(0, 9) < 7) h = good_header();
            else if ($urandom_range(0, 1)) h = $urandom;
            else begin
                h = good_header();
                h[$urandom_range(10, 31)] ^= 1'b1;
            end
            send_header(h);
        end
    endtask

    initial begin
        error_count = 0;
        burst_left = 0;
        stall_en = 1'b0;
        i_rst_n <= 1'b0;
        hdr_if.valid <= 1'b0;
        hdr_if.header_word <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_invalid_fields();
        stall_en = 1'b1;
        test_versions_layers();
        test_random();
        hdr_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
